### rtl/fnc_pkg.sv
// Shared types, constants and helper functions for the float-to-code quantizer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package fnc_pkg;

  localparam int MANT_W = 53;                 // binary64 significand with hidden bit
  localparam int COEF_W = 33;                 // scale factors used in each compare pass
  localparam int EXP_W  = 12;                 // signed exponent of a significand LSB
  localparam int PROD_W = COEF_W + MANT_W;
  localparam int NTERM  = 3;
  localparam int CODE_W = 32;
  localparam int QBIT_W = 6;                  // quotient bit index, 0 to 32

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NON_FINITE  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW    = 2'd3;

  localparam logic [EXP_W-1:0] EXP_SUBNORM = 12'hBCE;   // -1074
  localparam logic [EXP_W-1:0] EXP_BIAS    = 12'd1075;

  localparam logic [63:0] LOWER_RESET = 64'h0000_0000_0000_0000;
  localparam logic [63:0] UPPER_RESET = 64'h3ff0_0000_0000_0000;
  localparam logic [31:0] LCODE_RESET = 32'd65535;

  localparam logic [1:0] REG_LOWER = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_LCODE = 2'd2;

  typedef struct packed {
    logic              neg;
    logic [MANT_W-1:0] mag;
    logic [EXP_W-1:0]  exp;
  } dyad_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sum_res_t;

  function automatic dyad_t split_bits(input logic [63:0] b);
    dyad_t d;
    d.neg = b[63];
    if (b[62:52] == 11'd0) begin
      if (b[51:0] == 52'd0) begin
        d.neg = 1'b0;
      end
      d.mag = {1'b0, b[51:0]};
      d.exp = EXP_SUBNORM;
    end else begin
      d.mag = {1'b1, b[51:0]};
      d.exp = {1'b0, b[62:52]} - EXP_BIAS;
    end
    return d;
  endfunction

  function automatic logic [63:0] key_of(input logic [63:0] b);
    logic [63:0] x;
    x = (b[62:0] == 63'd0) ? 64'd0 : b;
    if (x[63]) begin
      return ~x;
    end
    return {1'b1, x[62:0]};
  endfunction

endpackage

### rtl/fnc_mul.sv
// Shift-and-add multiplier: one coefficient bit per cycle, MSB first.
// Depends on fnc_pkg for width defaults.
`timescale 1ns / 1ps
module fnc_mul #(
  parameter int CW = fnc_pkg::COEF_W,
  parameter int MW = fnc_pkg::MANT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CW-1:0]    coef,
  input  logic [MW-1:0]    mant,
  output logic             done,
  output logic [CW+MW-1:0] prod
);
  import fnc_pkg::*;

  localparam int PW   = CW + MW;
  localparam int CNTW = $clog2(CW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   creg;
  logic [MW-1:0]   mreg;
  logic [PW-1:0]   prod_next;

  assign prod_next = {prod[PW-2:0], 1'b0} + (creg[CW-1] ? PW'(mreg) : PW'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(CW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      creg <= coef;
      mreg <= mant;
      prod <= '0;
    end else if (busy) begin
      creg <= {creg[CW-2:0], 1'b0};
      prod <= prod_next;
    end
  end

endmodule

### rtl/fnc_colsum.sv
// Bit-serial signed sum of three scaled terms, LSB first over exponent positions;
// reports the sign and zeroness of the sum. Depends on fnc_pkg.
`timescale 1ns / 1ps
module fnc_colsum (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic [fnc_pkg::NTERM-1:0][fnc_pkg::PROD_W-1:0] prods,
  input  logic [fnc_pkg::NTERM-1:0][fnc_pkg::EXP_W-1:0]  exps,
  input  logic [fnc_pkg::NTERM-1:0]                negs,
  output logic                                     done,
  output fnc_pkg::sum_res_t                        res
);
  import fnc_pkg::*;

  logic [PROD_W-1:0]       r [NTERM];
  logic signed [EXP_W-1:0] e [NTERM];
  logic [NTERM-1:0]        s;
  logic signed [EXP_W-1:0] p;
  logic signed [3:0]       c;
  logic                    nz;
  logic                    busy;

  logic [NTERM-1:0]        pend;
  logic [NTERM-1:0]        act;
  logic signed [4:0]       sum;
  logic signed [EXP_W-1:0] nxt;
  logic                    stable;

  always_comb begin
    sum = {c[3], c};
    nxt = {1'b0, {(EXP_W-1){1'b1}}};
    for (int i = 0; i < NTERM; i++) begin
      pend[i] = (r[i] != '0);
      act[i]  = pend[i] && (p >= e[i]);
      if (act[i] && r[i][0]) begin
        sum = s[i] ? sum - 5'sd1 : sum + 5'sd1;
      end
      if (pend[i] && (e[i] < nxt)) begin
        nxt = e[i];
      end
    end
    stable = (c == 4'sd0) || (c == -4'sd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && !(|act) && !(|pend) && stable) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < NTERM; i++) begin
        r[i] <= prods[i];
        e[i] <= $signed(exps[i]);
      end
      s  <= negs;
      p  <= {1'b1, {(EXP_W-1){1'b0}}};
      c  <= 4'sd0;
      nz <= 1'b0;
    end else if (busy) begin
      if ((|act) || !stable) begin
        // step one column: add active bits and the carry
        for (int i = 0; i < NTERM; i++) begin
          if (act[i]) begin
            r[i] <= r[i] >> 1;
          end
        end
        c  <= sum[4:1];
        nz <= nz | sum[0];
        p  <= p + 12'sd1;
      end else if (|pend) begin
        // carry settled in a gap: jump to the next term start
        nz <= nz | c[3];
        p  <= nxt;
      end else begin
        res.neg  <= c[3];
        res.zero <= !nz && (c == 4'sd0);
      end
    end
  end

endmodule

### rtl/float_to_normalized_code.sv
// Float-to-code quantizer top level: config port, handshake and division sequencer.
// Depends on fnc_pkg, fnc_mul and fnc_colsum.
// Each item takes 34 compare passes (33 quotient bits, one rounding pass), each a
//   serial multiply followed by a summation whose length is set by the exponent spread.
//   Non-finite, out-of-range and equal-bound values skip the passes and finish directly.
// One item at a time; a new transfer is taken once the previous result is registered.
// Reset (synchronous) clears control state and restores the configuration defaults.
`timescale 1ns / 1ps
module float_to_normalized_code (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] value_bits,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [31:0] code,
  output logic [1:0]  status,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import fnc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_SSTART = 3'd3;
  localparam logic [2:0] S_SWAIT  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [63:0]       lo_bits;
  logic [63:0]       hi_bits;
  logic [31:0]       lcode;
  logic [1:0]        ridx;

  logic [2:0]        state;
  logic [63:0]       vreg;
  logic [COEF_W-1:0] q;
  logic [QBIT_W-1:0] k;
  logic              rnd;
  logic [31:0]       fin_code;
  logic [1:0]        fin_status;

  dyad_t             dv, dl, dh;
  logic [63:0]       kv;
  logic [COEF_W-1:0] t, ca, cb, cmag;
  logic [COEF_W:0]   cdiff;
  logic              bneg;
  logic              round_up;
  logic [COEF_W-1:0] qf;

  logic [NTERM-1:0][COEF_W-1:0] coefs;
  logic [NTERM-1:0][MANT_W-1:0] mants;
  logic [NTERM-1:0][PROD_W-1:0] prods;
  logic [NTERM-1:0][EXP_W-1:0]  exps;
  logic [NTERM-1:0]             negs;
  logic [NTERM-1:0]             mdone;
  logic                         sdone;
  sum_res_t                     sres;

  // configuration port
  assign pready = 1'b1;
  assign ridx   = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_bits <= LOWER_RESET;
      hi_bits <= UPPER_RESET;
      lcode   <= LCODE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_LOWER: lo_bits <= pwdata;
        REG_UPPER: hi_bits <= pwdata;
        REG_LCODE: lcode   <= pwdata[31:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_LOWER: prdata = lo_bits;
      REG_UPPER: prdata = hi_bits;
      REG_LCODE: prdata = {32'd0, lcode};
      default:   prdata = 64'd0;
    endcase
  end

  // compare pass: sign of A*(v - lo) - B*(hi - lo) as three terms
  assign dv    = split_bits(vreg);
  assign dl    = split_bits(lo_bits);
  assign dh    = split_bits(hi_bits);
  assign kv    = key_of(value_bits);
  assign t     = q | (COEF_W'(1) << k);
  assign ca    = rnd ? {lcode, 1'b0} : {1'b0, lcode};
  assign cb    = rnd ? {q[31:0], 1'b1} : t;
  assign cdiff = {1'b0, cb} - {1'b0, ca};
  assign bneg  = cdiff[COEF_W];
  assign cmag  = bneg ? COEF_W'(-cdiff) : cdiff[COEF_W-1:0];

  assign coefs = {cb, cmag, ca};
  assign mants = {dh.mag, dl.mag, dv.mag};
  assign exps  = {dh.exp, dl.exp, dv.exp};
  assign negs  = {!dh.neg, dl.neg ^ bneg, dv.neg};

  for (genvar i = 0; i < NTERM; i++) begin : g_mul
    fnc_mul #(
      .CW (COEF_W),
      .MW (MANT_W)
    ) u_mul (
      .clk   (clk),
      .rst   (rst),
      .start (state == S_MSTART),
      .coef  (coefs[i]),
      .mant  (mants[i]),
      .done  (mdone[i]),
      .prod  (prods[i])
    );
  end

  fnc_colsum u_colsum (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SSTART),
    .prods (prods),
    .exps  (exps),
    .negs  (negs),
    .done  (sdone),
    .res   (sres)
  );

  assign round_up = (!sres.neg && !sres.zero) || (sres.zero && q[0]);
  assign qf       = q + COEF_W'(round_up);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            vreg <= value_bits;
            if (value_bits[62:52] == 11'h7ff) begin
              fin_code   <= 32'd0;
              fin_status <= ST_NON_FINITE;
              state      <= S_FIN;
            end else if (kv < key_of(lo_bits) || kv > key_of(hi_bits)) begin
              fin_code   <= 32'd0;
              fin_status <= ST_OUTSIDE;
              state      <= S_FIN;
            end else if (key_of(lo_bits) == key_of(hi_bits)) begin
              fin_code   <= 32'd0;
              fin_status <= ST_OK;
              state      <= S_FIN;
            end else begin
              q     <= '0;
              k     <= QBIT_W'(COEF_W - 1);
              rnd   <= 1'b0;
              state <= S_MSTART;
            end
          end
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (&mdone) begin
            state <= S_SSTART;
          end
        end
        S_SSTART: state <= S_SWAIT;
        S_SWAIT: begin
          if (sdone) begin
            if (!rnd) begin
              if (!sres.neg) begin
                q <= t;
              end
              if (k == '0) begin
                rnd <= 1'b1;
              end else begin
                k <= k - QBIT_W'(1);
              end
              state <= S_MSTART;
            end else begin
              if (qf > {1'b0, lcode}) begin
                fin_code   <= 32'd0;
                fin_status <= ST_OVERFLOW;
              end else begin
                fin_code   <= qf[31:0];
                fin_status <= ST_OK;
              end
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      code   <= fin_code;
      status <= fin_status;
    end
  end

endmodule
